// ===== sv/quadratic_root_solver_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared concurrent assertion forms for the solver RTL.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication
`define QRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared constants, result kind codes and width helpers.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_W          = 40;
    localparam int KIND_W         = 2;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_NONE     = 2'd0;
    localparam kind_t KIND_DISTINCT = 2'd1;
    localparam kind_t KIND_REPEATED = 2'd2;
    localparam kind_t KIND_COMPLEX  = 2'd3;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // discriminant width, exact up to 31-bit coefficients, else modulo 2^64
    function automatic int qrs_disc_width(input int w);
        return (2 * w + 2 > 64) ? 64 : 2 * w + 2;
    endfunction

endpackage

// ===== sv/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One restoring digit of the floored square root; registered hand-on.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
    parameter int ROOT_W = 33,
    parameter int TAG_W  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  prev_valid,
    input  logic [2*ROOT_W-1:0]   prev_rad,
    input  logic [ROOT_W+1:0]     prev_rem,
    input  logic [ROOT_W-1:0]     prev_root,
    input  logic [TAG_W-1:0]      prev_tag,
    output logic                  valid,
    output logic [2*ROOT_W-1:0]   rad,
    output logic [ROOT_W+1:0]     rem,
    output logic [ROOT_W-1:0]     root,
    output logic [TAG_W-1:0]      tag
);

    logic                valid_reg;
    logic [2*ROOT_W-1:0] rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [TAG_W-1:0]    tag_reg;

    logic [2*ROOT_W-1:0] rad_next;
    logic [ROOT_W+1:0]   rem_next;
    logic [ROOT_W-1:0]   root_next;
    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic                take;

    always_comb
    begin
        rem_sh    = {prev_rem[ROOT_W-1:0], prev_rad[2*ROOT_W-1 -: 2]};
        trial     = {prev_root, 2'b01};
        take      = (rem_sh >= trial);
        rem_next  = take ? (rem_sh - trial) : rem_sh;
        root_next = {prev_root[ROOT_W-2:0], take};
        rad_next  = {prev_rad[2*ROOT_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            tag_reg  <= prev_tag;
        end
    end

    assign valid = valid_reg;
    assign rad   = rad_reg;
    assign rem   = rem_reg;
    assign root  = root_reg;
    assign tag   = tag_reg;

endmodule

// ===== sv/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit for two lanes sharing a divisor.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 17,
    parameter int TAG_W = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        prev_valid,
    input  logic [DEN_W-1:0]            prev_den,
    input  logic [1:0][NUM_W-1:0]       prev_pq,
    input  logic [1:0][DEN_W-1:0]       prev_rem,
    input  logic [TAG_W-1:0]            prev_tag,
    output logic                        valid,
    output logic [DEN_W-1:0]            den,
    output logic [1:0][NUM_W-1:0]       pq,
    output logic [1:0][DEN_W-1:0]       rem,
    output logic [TAG_W-1:0]            tag
);

    logic                  valid_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [1:0][NUM_W-1:0] pq_reg;
    logic [1:0][DEN_W-1:0] rem_reg;
    logic [TAG_W-1:0]      tag_reg;

    logic [1:0][NUM_W-1:0] pq_next;
    logic [1:0][DEN_W-1:0] rem_next;

    always_comb
    begin
        logic [DEN_W:0] rem_sh;
        logic [DEN_W:0] den_x;
        logic [DEN_W:0] diff;
        logic           take;
        den_x = {1'b0, prev_den};
        for (int l = 0; l < 2; l++)
        begin
            rem_sh      = {prev_rem[l], prev_pq[l][NUM_W-1]};
            diff        = rem_sh - den_x;
            take        = (rem_sh >= den_x);
            rem_next[l] = take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            pq_next[l]  = {prev_pq[l][NUM_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= prev_den;
            pq_reg  <= pq_next;
            rem_reg <= rem_next;
            tag_reg <= prev_tag;
        end
    end

    assign valid = valid_reg;
    assign den   = den_reg;
    assign pq    = pq_reg;
    assign rem   = rem_reg;
    assign tag   = tag_reg;

endmodule

// ===== sv/quadratic_root_solver_unit.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver
// Classifies a*x^2 + b*x + c and returns the roots in signed Q24.16. One
// request is taken every cycle while coef_stall is low. The pipeline is
// built from two cell chains: the square root takes one root bit per cell
// and the two truncating dividers by 2a take one quotient bit per cell. A
// request is taken while a finished result waits on the output as long as
// the last divider cell is empty.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_unit_defines.svh"

module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              coef_valid,
    output logic                              coef_stall,
    input  logic signed [COEF_WIDTH-1:0]      coef_a,
    input  logic signed [COEF_WIDTH-1:0]      coef_b,
    input  logic signed [COEF_WIDTH-1:0]      coef_c,
    output logic                              root_valid,
    input  logic                              root_stall,
    output qrs_pkg::kind_t                    root_kind,
    output logic signed [qrs_pkg::OUT_W-1:0]  first_value,
    output logic signed [qrs_pkg::OUT_W-1:0]  second_value
);

    import qrs_pkg::*;

    localparam int W         = COEF_WIDTH;
    localparam int DISC_W    = qrs_disc_width(COEF_WIDTH);
    localparam int ROOT_W    = DISC_W / 2 + FRAC_BITS;
    localparam int NB_W      = COEF_WIDTH + FRAC_BITS + 1;
    localparam int NUM_W     = ROOT_W + 2;
    localparam int QM_W      = ROOT_W + 1;
    localparam int DEN_W     = COEF_WIDTH + 1;
    localparam int SQ_TAG_W  = KIND_W + COEF_WIDTH + NB_W;
    localparam int DV_TAG_W  = KIND_W + 2;
    localparam int QX_W      = ((QM_W > OUT_W) ? QM_W : OUT_W) + 1;

    logic en;
    logic out_upd;
    logic dv_last_valid;

    // front stages
    logic                    s1_valid_reg;
    logic signed [W-1:0]     s1_a_reg, s1_b_reg, s1_c_reg;
    logic                    s2_valid_reg;
    logic signed [W-1:0]     s2_a_reg, s2_b_reg;
    logic signed [2*W-1:0]   s2_bb_reg, s2_ac_reg;
    logic signed [2*W-1:0]   s2_bb_next, s2_ac_next;
    logic                    s3_valid_reg;
    logic signed [W-1:0]     s3_a_reg, s3_b_reg;
    logic signed [DISC_W-1:0] s3_d_reg, s3_d_next;
    logic signed [DISC_W-1:0] bb_x, ac_x;
    logic                    s4_valid_reg;
    logic [DISC_W-1:0]       s4_mag_reg, s4_mag_next;
    kind_t                   s4_kind_reg, s4_kind_next;
    logic signed [W-1:0]     s4_a_reg;
    logic signed [NB_W-1:0]  s4_nb_reg, s4_nb_next;

    // square root chain
    logic                    sq_valid [0:ROOT_W];
    logic [2*ROOT_W-1:0]     sq_rad   [0:ROOT_W];
    logic [ROOT_W+1:0]       sq_rem   [0:ROOT_W];
    logic [ROOT_W-1:0]       sq_root  [0:ROOT_W];
    logic [SQ_TAG_W-1:0]     sq_tag   [0:ROOT_W];

    // numerator stages
    kind_t                   t_kind;
    logic signed [W-1:0]     t_a;
    logic signed [NB_W-1:0]  t_nb;
    logic signed [NUM_W-1:0] nb_x, s_x, num1_next, num2_next;
    logic                    s5_valid_reg;
    logic signed [NUM_W-1:0] s5_num1_reg, s5_num2_reg;
    kind_t                   s5_kind_reg;
    logic signed [W-1:0]     s5_a_reg;
    logic [W-1:0]            abs_a;
    logic [1:0][QM_W-1:0]    s6_pq_next;
    logic                    q1_neg, q2_neg;

    // divider chain
    logic                    dv_valid [0:QM_W];
    logic [DEN_W-1:0]        dv_den   [0:QM_W];
    logic [1:0][QM_W-1:0]    dv_pq    [0:QM_W];
    logic [1:0][DEN_W-1:0]   dv_rem   [0:QM_W];
    logic [DV_TAG_W-1:0]     dv_tag   [0:QM_W];

    logic                    s6_valid_reg;
    logic [DEN_W-1:0]        s6_den_reg;
    logic [1:0][QM_W-1:0]    s6_pq_reg;
    logic [DV_TAG_W-1:0]     s6_tag_reg;

    // output register
    logic                    root_valid_reg;
    kind_t                   root_kind_reg;
    logic [1:0][OUT_W-1:0]   val_reg, val_next;

    assign dv_last_valid = dv_valid[QM_W];
    assign en            = !dv_last_valid || !root_valid_reg || !root_stall;
    assign out_upd       = !root_valid_reg || !root_stall;
    assign coef_stall    = !en;

    // stage 2: products
    assign s2_bb_next = s1_b_reg * s1_b_reg;
    assign s2_ac_next = s1_a_reg * s1_c_reg;

    // stage 3: discriminant
    assign bb_x      = DISC_W'(s2_bb_reg);
    assign ac_x      = DISC_W'(s2_ac_reg);
    assign s3_d_next = bb_x - (ac_x <<< 2);

    // stage 4: magnitude and classification
    always_comb
    begin
        s4_mag_next = s3_d_reg[DISC_W-1] ? DISC_W'(-s3_d_reg) : DISC_W'(s3_d_reg);
        if (s3_a_reg == '0)
        begin
            s4_kind_next = KIND_NONE;
        end
        else if (s3_d_reg == '0)
        begin
            s4_kind_next = KIND_REPEATED;
        end
        else if (s3_d_reg[DISC_W-1])
        begin
            s4_kind_next = KIND_COMPLEX;
        end
        else
        begin
            s4_kind_next = KIND_DISTINCT;
        end
        s4_nb_next = -(NB_W'(s3_b_reg) <<< FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= coef_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= sq_valid[ROOT_W];
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg    <= coef_a;
            s1_b_reg    <= coef_b;
            s1_c_reg    <= coef_c;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_bb_reg   <= s2_bb_next;
            s2_ac_reg   <= s2_ac_next;
            s3_a_reg    <= s2_a_reg;
            s3_b_reg    <= s2_b_reg;
            s3_d_reg    <= s3_d_next;
            s4_mag_reg  <= s4_mag_next;
            s4_kind_reg <= s4_kind_next;
            s4_a_reg    <= s3_a_reg;
            s4_nb_reg   <= s4_nb_next;
            s5_num1_reg <= num1_next;
            s5_num2_reg <= num2_next;
            s5_kind_reg <= t_kind;
            s5_a_reg    <= t_a;
            s6_den_reg  <= {abs_a, 1'b0};
            s6_pq_reg   <= s6_pq_next;
            s6_tag_reg  <= {s5_kind_reg, q2_neg, q1_neg};
        end
    end

    // square root chain: radicand is |d| scaled by 2^(2*FRAC_BITS)
    assign sq_valid[0] = s4_valid_reg;
    assign sq_rad[0]   = (2*ROOT_W)'(s4_mag_reg) << (2 * FRAC_BITS);
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_tag[0]   = {s4_kind_reg, s4_a_reg, s4_nb_reg};

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(
            .ROOT_W (ROOT_W),
            .TAG_W  (SQ_TAG_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (sq_valid[i]),
            .prev_rad   (sq_rad[i]),
            .prev_rem   (sq_rem[i]),
            .prev_root  (sq_root[i]),
            .prev_tag   (sq_tag[i]),
            .valid      (sq_valid[i+1]),
            .rad        (sq_rad[i+1]),
            .rem        (sq_rem[i+1]),
            .root       (sq_root[i+1]),
            .tag        (sq_tag[i+1])
        );
    end

    // stage 5: numerators
    assign {t_kind, t_a, t_nb} = sq_tag[ROOT_W];
    assign nb_x      = NUM_W'(t_nb);
    assign s_x       = NUM_W'(sq_root[ROOT_W]);
    assign num1_next = (t_kind == KIND_COMPLEX) ? nb_x : nb_x + s_x;
    assign num2_next = (t_kind == KIND_COMPLEX) ? s_x : nb_x - s_x;

    // stage 6: magnitudes and quotient signs
    assign abs_a  = s5_a_reg[W-1] ? W'(-s5_a_reg) : W'(s5_a_reg);
    assign q1_neg = s5_num1_reg[NUM_W-1] ^ s5_a_reg[W-1];
    assign q2_neg = s5_num2_reg[NUM_W-1] ^ s5_a_reg[W-1];
    assign s6_pq_next[0] = s5_num1_reg[NUM_W-1] ? QM_W'(-s5_num1_reg) : QM_W'(s5_num1_reg);
    assign s6_pq_next[1] = s5_num2_reg[NUM_W-1] ? QM_W'(-s5_num2_reg) : QM_W'(s5_num2_reg);

    // divider chain
    assign dv_valid[0] = s6_valid_reg;
    assign dv_den[0]   = s6_den_reg;
    assign dv_pq[0]    = s6_pq_reg;
    assign dv_rem[0]   = '0;
    assign dv_tag[0]   = s6_tag_reg;

    for (genvar i = 0; i < QM_W; i++)
    begin : g_div
        qrs_div_cell #(
            .NUM_W (QM_W),
            .DEN_W (DEN_W),
            .TAG_W (DV_TAG_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (dv_valid[i]),
            .prev_den   (dv_den[i]),
            .prev_pq    (dv_pq[i]),
            .prev_rem   (dv_rem[i]),
            .prev_tag   (dv_tag[i]),
            .valid      (dv_valid[i+1]),
            .den        (dv_den[i+1]),
            .pq         (dv_pq[i+1]),
            .rem        (dv_rem[i+1]),
            .tag        (dv_tag[i+1])
        );
    end

    // sign, saturation, error masking
    always_comb
    begin
        logic [QX_W-1:0] qx;
        logic [QX_W-1:0] qneg;
        logic [QX_W-1:0] pos_lim;
        logic [QX_W-1:0] neg_lim;
        pos_lim = QX_W'(OUT_MAX);
        neg_lim = QX_W'(OUT_MIN);
        for (int l = 0; l < 2; l++)
        begin
            qx   = QX_W'(dv_pq[QM_W][l]);
            qneg = -qx;
            if (dv_tag[QM_W][KIND_W+1:2] == KIND_NONE)
            begin
                val_next[l] = '0;
            end
            else if (!dv_tag[QM_W][l])
            begin
                val_next[l] = (qx > pos_lim) ? OUT_MAX : qx[OUT_W-1:0];
            end
            else
            begin
                val_next[l] = (qx > neg_lim) ? OUT_MIN : qneg[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_valid_reg <= 1'b0;
        end
        else if (out_upd)
        begin
            root_valid_reg <= dv_last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_upd && dv_last_valid)
        begin
            root_kind_reg <= dv_tag[QM_W][KIND_W+1:2];
            val_reg       <= val_next;
        end
    end

    assign root_valid   = root_valid_reg;
    assign root_kind    = root_kind_reg;
    assign first_value  = val_reg[0];
    assign second_value = val_reg[1];

    `QRS_ASSERT_NOW(a_none_is_zero, clk, rst_n, root_valid && root_kind == KIND_NONE, first_value == '0 && second_value == '0, "error result carries non-zero roots")
    `QRS_ASSERT_NOW(a_repeated_equal, clk, rst_n, root_valid && root_kind == KIND_REPEATED, first_value == second_value, "repeated root differs between fields")
    `QRS_ASSERT_NOW(a_drained_no_stall, clk, rst_n, !dv_last_valid, !coef_stall, "request stalled with empty chain tail")
    `QRS_ASSERT_NEXT(a_no_phantom_result, clk, rst_n, !root_valid && !dv_last_valid, !root_valid, "result appeared without a finished request")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Streams coefficient sets into the solver with random gaps and output
// stalls. Each accepted request is solved by a local predictor, which
// forms the exact discriminant, a floored fixed-point square root and
// truncating, saturating divisions by 2a. Every accepted result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import qrs_pkg::*;

    localparam int     COEF_W         = COEF_WIDTH_DEF;
    localparam int     FRAC           = FRAC_BITS_DEF;
    localparam int     DRAIN_CYCLES   = 120;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     RANDOM_ITEMS   = 1500;
    localparam longint OUT_HI         = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LO         = -OUT_HI - 1;

    typedef struct {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } coef_set_t;

    typedef struct {
        kind_t                   kind;
        logic signed [OUT_W-1:0] first;
        logic signed [OUT_W-1:0] second;
    } roots_t;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     coef_valid   = 1'b0;
    logic                     coef_stall;
    logic signed [COEF_W-1:0] coef_a       = '0;
    logic signed [COEF_W-1:0] coef_b       = '0;
    logic signed [COEF_W-1:0] coef_c       = '0;
    logic                     root_valid;
    logic                     root_stall   = 1'b0;
    kind_t                    root_kind;
    logic signed [OUT_W-1:0]  first_value;
    logic signed [OUT_W-1:0]  second_value;

    coef_set_t coef_pending[$];
    roots_t    roots_expected[$];
    int        fail_count;
    int        idle_cycles;

    quadratic_root_solver_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .coef_valid   (coef_valid),
        .coef_stall   (coef_stall),
        .coef_a       (coef_a),
        .coef_b       (coef_b),
        .coef_c       (coef_c),
        .root_valid   (root_valid),
        .root_stall   (root_stall),
        .root_kind    (root_kind),
        .first_value  (first_value),
        .second_value (second_value)
    );

    // floor(sqrt(mag * 2^(2*FRAC))), one root digit per pass
    function automatic longint unsigned isqrt_scaled(input longint unsigned mag);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        longint unsigned pair;
        root = 0;
        rem  = 0;
        for (int i = 32 + FRAC - 1; i >= 0; i--)
        begin
            pair = 0;
            if (i >= FRAC)
                pair = (mag >> (2 * (i - FRAC))) & 64'd3;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic logic signed [OUT_W-1:0] div_clip(input longint num, input longint den);
        longint q;
        q = num / den;
        if (q > OUT_HI)
            q = OUT_HI;
        if (q < OUT_LO)
            q = OUT_LO;
        return q[OUT_W-1:0];
    endfunction

    function automatic roots_t solve_quadratic(input coef_set_t cs);
        roots_t r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint mag;
        longint s;
        longint nb;
        longint den;
        a = cs.a;
        b = cs.b;
        c = cs.c;
        if (a == 0)
        begin
            r.kind   = KIND_NONE;
            r.first  = '0;
            r.second = '0;
            return r;
        end
        disc = b * b - 4 * a * c;
        mag  = (disc < 0) ? -disc : disc;
        s    = longint'(isqrt_scaled(mag));
        nb   = -b * (longint'(1) <<< FRAC);
        den  = 2 * a;
        if (disc == 0)
        begin
            r.kind   = KIND_REPEATED;
            r.first  = div_clip(nb, den);
            r.second = r.first;
        end
        else if (disc > 0)
        begin
            r.kind   = KIND_DISTINCT;
            r.first  = div_clip(nb + s, den);
            r.second = div_clip(nb - s, den);
        end
        else
        begin
            r.kind   = KIND_COMPLEX;
            r.first  = div_clip(nb, den);
            r.second = div_clip(s, den);
        end
        return r;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic add_coefs(input int a, input int b, input int c);
        coef_set_t cs;
        cs.a = a[COEF_W-1:0];
        cs.b = b[COEF_W-1:0];
        cs.c = c[COEF_W-1:0];
        coef_pending.push_back(cs);
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] exp_v,
                               input logic [OUT_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // request driver
    int gap_left;
    int drive_burst;
    bit drive_quiet;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_valid  <= 1'b0;
            coef_a      <= '0;
            coef_b      <= '0;
            coef_c      <= '0;
            gap_left    = 0;
            drive_burst = 100;
            drive_quiet = 1'b0;
        end
        else if (!coef_valid || !coef_stall)
        begin
            if (drive_burst == 0)
            begin
                drive_quiet = ($urandom_range(0, 3) == 0);
                drive_burst = $urandom_range(20, 200);
            end
            else
                drive_burst--;
            if (gap_left > 0)
            begin
                gap_left--;
                coef_valid <= 1'b0;
            end
            else if (coef_pending.size() > 0)
            begin
                coef_set_t cs;
                cs = coef_pending.pop_front();
                coef_a     <= cs.a;
                coef_b     <= cs.b;
                coef_c     <= cs.c;
                coef_valid <= 1'b1;
                gap_left   = pick_gap(drive_quiet);
            end
            else
                coef_valid <= 1'b0;
        end
    end

    // output stall
    int stall_left;
    int stall_burst;
    bit stall_quiet;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_stall  <= 1'b0;
            stall_left  = 0;
            stall_burst = 100;
            stall_quiet = 1'b0;
        end
        else
        begin
            if (stall_burst == 0)
            begin
                stall_quiet = ($urandom_range(0, 3) == 0);
                stall_burst = $urandom_range(20, 200);
            end
            else
                stall_burst--;
            if (stall_left > 0)
            begin
                stall_left--;
                root_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap(stall_quiet);
                root_stall <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            coef_set_t cs;
            roots_t    exp_r;
            bit        moved;
            moved = 1'b0;
            if (coef_valid && !coef_stall)
            begin
                cs.a = coef_a;
                cs.b = coef_b;
                cs.c = coef_c;
                roots_expected.push_back(solve_quadratic(cs));
                moved = 1'b1;
            end
            if (root_valid && !root_stall)
            begin
                moved = 1'b1;
                if (roots_expected.size() == 0)
                begin
                    $display("%0t unexpected result: kind %h first %h second %h",
                             $time, root_kind, first_value, second_value);
                    fail_count++;
                end
                else
                begin
                    exp_r = roots_expected.pop_front();
                    check_field("root_kind", OUT_W'(exp_r.kind), OUT_W'(root_kind));
                    check_field("first_value", exp_r.first, first_value);
                    check_field("second_value", exp_r.second, second_value);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int sel;
        int k;
        int p;
        int r1;
        int r2;
        fail_count  = 0;
        idle_cycles = 0;

        // leading coefficient zero
        add_coefs(0, 0, 0);
        add_coefs(0, -32768, 32767);
        add_coefs(0, 32767, -32768);
        // distinct real roots
        add_coefs(1, -3, 2);
        add_coefs(-1, 3, -2);
        add_coefs(1, 1, -1);
        add_coefs(1, -32768, -32768);
        add_coefs(-32768, -32768, 32767);
        add_coefs(1, 32767, 0);
        add_coefs(32767, -32768, -32768);
        // repeated root
        add_coefs(1, 2, 1);
        add_coefs(-32768, -32768, -8192);
        add_coefs(32767, 0, 0);
        add_coefs(-3, 12, -12);
        // complex pair, with negative a giving a negative imaginary part
        add_coefs(1, 0, 1);
        add_coefs(-1, 0, -1);
        add_coefs(32767, 32767, 32767);
        add_coefs(-32768, 32767, -32768);
        add_coefs(-32768, -32768, -32768);
        add_coefs(2, -3, 5);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
                add_coefs(0, $urandom, $urandom);
            else if (sel < 25)
            begin
                k = $urandom_range(1, 20) * ($urandom_range(0, 1) ? 1 : -1);
                p = int'($urandom_range(0, 80)) - 40;
                add_coefs(k, -2 * k * p, k * p * p);
            end
            else if (sel < 45)
            begin
                k  = $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1);
                r1 = int'($urandom_range(0, 60)) - 30;
                r2 = int'($urandom_range(0, 60)) - 30;
                add_coefs(k, -k * (r1 + r2), k * r1 * r2);
            end
            else if (sel < 60)
                add_coefs(int'($urandom_range(0, 31)) - 16, int'($urandom_range(0, 31)) - 16,
                          int'($urandom_range(0, 31)) - 16);
            else
                add_coefs($urandom, $urandom, $urandom);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (coef_pending.size() > 0 || coef_valid || roots_expected.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (roots_expected.size() > 0)
        begin
            $display("%0t %0d results never arrived", $time, roots_expected.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
